>>> src/kpm_pkg.sv
// Shared constants, types and the mode page decoder for the knob pickup block.
package kpm_pkg;

   localparam int NUM_KNOBS      = 8;
   localparam int NUM_MODES      = 8;
   localparam int ADC_FULL_SCALE = 4095;

   localparam int KNOB_W = 3;
   localparam int PAGE_W = 3;
   localparam int VAL_W  = 12;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 12;

   // Width of one mode band; never zero.
   localparam int BAND = (ADC_FULL_SCALE / NUM_MODES == 0) ? 1 : ADC_FULL_SCALE / NUM_MODES;

   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MODE_KNOB = 1'd1;

   // One memory entry per knob.
   typedef struct packed {
      logic [VAL_W-1:0] reference;
      logic [VAL_W-1:0] latest;
   } kpm_entry_type;

   localparam int ENTRY_W = $bits(kpm_entry_type);

   // Band index of a mode knob value, clamped to the top mode. Each band
   // boundary is an independent constant compare; the page is their count.
   function automatic logic [PAGE_W-1:0] mode_page(input logic [VAL_W-1:0] v);
      int cnt;
      cnt = 0;
      for (int k = 1; k < NUM_MODES; k++) begin
         if (32'(v) >= 32'(k * BAND)) begin
            cnt = cnt + 1;
         end
      end
      return PAGE_W'(cnt);
   endfunction

endpackage

>>> src/kpm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module kpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/knob_pickup_with_mode_pages_core.sv
// Knob soft-takeover with mode pages: per-knob state in a RAM, sequenced updates.
// A sample without the scan mark is accepted, then its knob entry is written back.
// A scan-marked sample then reads the mode knob entry and checks its page. When the
// page changes, every knob entry is read and written back; otherwise each eligible
// knob is read and emitted in turn through the single read port of the knob RAM.
// Reset is synchronous; it clears entry valid bits so unwritten knobs read as zero.
module knob_pickup_with_mode_pages_core (
   input  logic                             clock,
   input  logic                             reset,
   // Input channel. tdata: knob_index[2:0], sample[14:3], zero fill.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,
   input  logic                             req_tlast,
   // Result channel. tdata: out_knob[2:0], page[5:3], level[17:6], zero fill.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [23:0]                      rsp_tdata,
   output logic                             rsp_tlast,
   // Configuration writes.
   input  logic                             csr_we,
   input  logic [kpm_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [kpm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import kpm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_MODE_RD,
      S_MODE_CHK,
      S_COPY_RD,
      S_COPY_WR,
      S_EMIT_RD,
      S_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [KNOB_W-1:0]       knob_ff, knob_in;
   logic [VAL_W-1:0]        sample_ff, sample_in;
   logic                    eos_ff, eos_in;
   logic [KNOB_W-1:0]       cursor_ff, cursor_in;
   logic [NUM_KNOBS-1:0]    flag_ff, flag_in;
   logic [NUM_KNOBS-1:0]    valid_ff, valid_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [PAGE_W-1:0]       page_ff, page_in;
   logic [VAL_W-1:0]        thresh_ff, thresh_in;
   logic [KNOB_W-1:0]       mode_knob_ff, mode_knob_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [KNOB_W-1:0]       rsp_knob_ff, rsp_knob_in;
   logic [PAGE_W-1:0]       rsp_page_ff, rsp_page_in;
   logic [VAL_W-1:0]        rsp_level_ff, rsp_level_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    ram_wr_en, ram_rd_en;
   logic [KNOB_W-1:0]       ram_wr_addr, ram_rd_addr;
   kpm_entry_type           ram_wr_data, ram_rd_data, rd_entry;

   logic [NUM_KNOBS-1:0]    elig;
   logic [NUM_KNOBS-1:0]    above_mask;
   logic [VAL_W-1:0]        diff;
   logic                    picked;
   logic [PAGE_W-1:0]       new_page;
   logic                    out_free;

   kpm_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(NUM_KNOBS)
   ) u_knob_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // An entry never written reads as all zeros.
   assign rd_entry = rd_valid_ff ? ram_rd_data : kpm_entry_type'('0);

   // Knobs that report this scan: picked up and not the mode knob.
   always_comb begin
      for (int i = 0; i < NUM_KNOBS; i++) begin
         elig[i]       = flag_ff[i] && (KNOB_W'(i) != mode_knob_ff);
         above_mask[i] = KNOB_W'(i) > cursor_ff;
      end
   end

   // Pickup test against the stored reference.
   assign diff     = (sample_ff > rd_entry.reference) ? sample_ff - rd_entry.reference
                                                      : rd_entry.reference - sample_ff;
   assign picked   = diff > thresh_ff;
   assign new_page = mode_page(rd_entry.latest);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer: memory read, modify and write back of knob entries, plus result emission.
   always_comb begin
      state_in     = state_ff;
      knob_in      = knob_ff;
      sample_in    = sample_ff;
      eos_in       = eos_ff;
      cursor_in    = cursor_ff;
      flag_in      = flag_ff;
      valid_in     = valid_ff;
      rd_valid_in  = rd_valid_ff;
      page_in      = page_ff;
      thresh_in    = thresh_ff;
      mode_knob_in = mode_knob_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_knob_in  = rsp_knob_ff;
      rsp_page_in  = rsp_page_ff;
      rsp_level_in = rsp_level_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = knob_ff;
      ram_wr_data  = '{reference: sample_ff, latest: sample_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = cursor_ff;

      if (csr_we) begin
         unique case (csr_addr)
            CSR_THRESHOLD: thresh_in    = csr_wdata;
            CSR_MODE_KNOB: mode_knob_in = csr_wdata[KNOB_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               knob_in     = req_tdata[KNOB_W-1:0];
               sample_in   = req_tdata[KNOB_W+VAL_W-1:KNOB_W];
               eos_in      = req_tlast;
               ram_rd_en   = 1'b1;
               ram_rd_addr = req_tdata[KNOB_W-1:0];
               rd_valid_in = valid_ff[req_tdata[KNOB_W-1:0]];
               state_in    = S_UPDATE;
            end
         end
         S_UPDATE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = '{reference: picked ? sample_ff : rd_entry.reference,
                            latest: sample_ff};
            valid_in[knob_ff] = 1'b1;
            if (picked) begin
               flag_in[knob_ff] = 1'b1;
            end
            state_in = eos_ff ? S_MODE_RD : S_IDLE;
         end
         S_MODE_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = mode_knob_ff;
            rd_valid_in = valid_ff[mode_knob_ff];
            state_in    = S_MODE_CHK;
         end
         S_MODE_CHK: begin
            cursor_in = '0;
            if (new_page != page_ff) begin
               page_in  = new_page;
               flag_in  = '0;
               state_in = S_COPY_RD;
            end else if (elig != '0) begin
               state_in = S_EMIT_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_COPY_RD: begin
            ram_rd_en   = 1'b1;
            rd_valid_in = valid_ff[cursor_ff];
            state_in    = S_COPY_WR;
         end
         S_COPY_WR: begin
            // Reference takes the latest value; flags were cleared on entry.
            ram_wr_en   = 1'b1;
            ram_wr_addr = cursor_ff;
            ram_wr_data = '{reference: rd_entry.latest, latest: rd_entry.latest};
            valid_in[cursor_ff] = 1'b1;
            cursor_in = cursor_ff + 1'b1;
            state_in  = (cursor_ff == KNOB_W'(NUM_KNOBS - 1)) ? S_IDLE : S_COPY_RD;
         end
         S_EMIT_RD: begin
            if (elig[cursor_ff]) begin
               ram_rd_en   = 1'b1;
               rd_valid_in = valid_ff[cursor_ff];
               state_in    = S_EMIT;
            end else begin
               cursor_in = cursor_ff + 1'b1;
            end
         end
         S_EMIT: begin
            // Hold the read data until the output register is free.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_knob_in  = cursor_ff;
               rsp_page_in  = page_ff;
               rsp_level_in = rd_entry.latest;
               rsp_last_in  = (elig & above_mask) == '0;
               cursor_in    = cursor_ff + 1'b1;
               state_in     = ((elig & above_mask) == '0) ? S_IDLE : S_EMIT_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cursor_ff    <= '0;
         flag_ff      <= '0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         page_ff      <= '0;
         thresh_ff    <= VAL_W'(32);
         mode_knob_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         flag_ff      <= flag_in;
         valid_ff     <= valid_in;
         rd_valid_ff  <= rd_valid_in;
         page_ff      <= page_in;
         thresh_ff    <= thresh_in;
         mode_knob_ff <= mode_knob_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      knob_ff      <= knob_in;
      sample_ff    <= sample_in;
      eos_ff       <= eos_in;
      rsp_knob_ff  <= rsp_knob_in;
      rsp_page_ff  <= rsp_page_in;
      rsp_level_ff <= rsp_level_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_level_ff, rsp_page_ff, rsp_knob_ff};
   assign rsp_tlast  = rsp_last_ff;

   // A page change always starts from cleared pickup flags.
   assert property (@(posedge clock) disable iff (reset)
      !$stable(page_ff) |-> (flag_ff == '0))
      else $error("page changed while pickup flags remained set");

   // A stalled result is never overwritten by the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_EMIT))
      else $error("sequencer left emit while output register was full");

   // Only picked-up knobs are fetched for output.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> flag_ff[cursor_ff])
      else $error("emitting a knob that is not picked up");

   // The copy sweep leaves every entry written.
   assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == S_COPY_WR && state_ff == S_IDLE) |-> (valid_ff == '1))
      else $error("copy sweep finished with unwritten entries");

endmodule

>>> tb/sv/knob_pickup_checker.sv
// Watches the knob pickup channels, predicts each knob update and compares results.
module knob_pickup_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [15:0]                    req_tdata,
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [23:0]                    rsp_tdata,
   input  logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [kpm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [kpm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             updates_pending,
   output int                             fail_count
);
   import kpm_pkg::*;

   // One knob update as it leaves the block.
   typedef struct packed {
      logic [KNOB_W-1:0] knob;
      logic [PAGE_W-1:0] page;
      logic [VAL_W-1:0]  level;
      logic              last;
   } knob_update_type;

   knob_update_type expected_updates[$];

   // Shadow copy of the block's registers and per-knob state.
   logic [VAL_W-1:0]  threshold;
   logic [KNOB_W-1:0] mode_sel;
   logic [VAL_W-1:0]  anchor_level[NUM_KNOBS];
   logic [VAL_W-1:0]  latest_level[NUM_KNOBS];
   logic              engaged[NUM_KNOBS];
   logic [PAGE_W-1:0] cur_page;

   int queued = 0;
   int mismatches = 0;

   assign updates_pending = queued;
   assign fail_count      = mismatches;

   // Mode band of a level; the top band absorbs readings at full scale.
   function automatic logic [PAGE_W-1:0] page_from_level(input logic [VAL_W-1:0] v);
      int width;
      int p;
      width = ADC_FULL_SCALE / NUM_MODES;
      if (width == 0) begin
         width = 1;
      end
      p = int'(v) / width;
      if (p > NUM_MODES - 1) begin
         p = NUM_MODES - 1;
      end
      return PAGE_W'(p);
   endfunction

   // Applies one accepted sample and queues the updates it releases.
   task automatic take_sample(input logic [KNOB_W-1:0] k, input logic [VAL_W-1:0] smp,
                              input logic eos);
      logic [VAL_W-1:0]  moved;
      logic [PAGE_W-1:0] np;
      knob_update_type   u;
      int                total;
      int                n;
      moved = (smp > anchor_level[k]) ? smp - anchor_level[k] : anchor_level[k] - smp;
      if (moved > threshold) begin
         engaged[k]      = 1'b1;
         anchor_level[k] = smp;
      end
      latest_level[k] = smp;
      if (!eos) begin
         return;
      end
      // A new page re-anchors every knob and drops all pickups.
      np = page_from_level(latest_level[mode_sel]);
      if (np != cur_page) begin
         cur_page = np;
         for (int i = 0; i < NUM_KNOBS; i++) begin
            anchor_level[i] = latest_level[i];
            engaged[i]      = 1'b0;
         end
      end
      total = 0;
      for (int i = 0; i < NUM_KNOBS; i++) begin
         if (engaged[i] && KNOB_W'(i) != mode_sel && total < NUM_KNOBS - 1) begin
            total++;
         end
      end
      n = 0;
      for (int i = 0; i < NUM_KNOBS; i++) begin
         if (engaged[i] && KNOB_W'(i) != mode_sel && n < total) begin
            u.knob  = KNOB_W'(i);
            u.page  = cur_page;
            u.level = latest_level[i];
            u.last  = (n == total - 1);
            expected_updates.push_back(u);
            n++;
         end
      end
   endtask

   // Registers first, then the outgoing transfer, then the incoming one.
   always @(posedge clock) begin
      knob_update_type got;
      knob_update_type want;
      if (reset) begin
         threshold = 12'd32;
         mode_sel  = '0;
         cur_page  = '0;
         for (int i = 0; i < NUM_KNOBS; i++) begin
            anchor_level[i] = '0;
            latest_level[i] = '0;
            engaged[i]      = 1'b0;
         end
         expected_updates.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_THRESHOLD) begin
               threshold = csr_wdata[VAL_W-1:0];
            end else if (csr_addr == CSR_MODE_KNOB) begin
               mode_sel = csr_wdata[KNOB_W-1:0];
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.knob  = rsp_tdata[2:0];
            got.page  = rsp_tdata[5:3];
            got.level = rsp_tdata[17:6];
            got.last  = rsp_tlast;
            if (expected_updates.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Unexpected update: knob %0d page %0d level %0d last %0b",
                           got.knob, got.page, got.level, got.last);
               end
            end else begin
               want = expected_updates.pop_front();
               if (got.knob != want.knob || got.page != want.page ||
                   got.level != want.level || got.last != want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Update mismatch: got knob %0d page %0d level %0d last %0b, %s",
                              got.knob, got.page, got.level, got.last,
                              $sformatf("expected knob %0d page %0d level %0d last %0b",
                                        want.knob, want.page, want.level, want.last));
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            take_sample(req_tdata[2:0], req_tdata[14:3], req_tlast);
         end
      end
      queued = expected_updates.size();
   end

endmodule

>>> tb/sv/testbench.sv
// Top of the knob pickup bench: clock, reset, sample stimulus, pacing and verdict.
module testbench;
   import kpm_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASES        = 6;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int updates_pending;
   int fail_count;
   int cycle_count = 0;
   int stall_left = 0;

   // When set, neither side idles.
   logic calm = 1'b0;

   // Last level sent per knob, and the page the mode knob is steered to.
   logic [VAL_W-1:0]  sent_level[NUM_KNOBS];
   logic [KNOB_W-1:0] mode_pick = '0;
   int                page_pick = 0;

   knob_pickup_with_mode_pages_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   knob_pickup_checker pickup_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .updates_pending (updates_pending),
      .fail_count      (fail_count)
   );

   always #1 clock = ~clock;

   // Hard stop if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Result side back-pressure.
   always @(negedge clock) begin
      int g;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         g = pick_gap();
         if (g > 0) begin
            rsp_tready <= 1'b0;
            stall_left = g - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // One sample transfer, preceded by a random gap.
   task automatic send(input int k, input int smp, input logic eos);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, VAL_W'(smp), KNOB_W'(k)};
      req_tlast  <= eos;
      sent_level[k] = VAL_W'(smp);
      do begin
         @(posedge clock);
      end while (!req_tready);
      @(negedge clock);
   endtask

   // Waits until every update has arrived and the block has had time to finish.
   task automatic settle();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (updates_pending != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes both registers on back-to-back cycles while the block is idle.
   task automatic program_regs(input int thr, input int mk);
      settle();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_THRESHOLD;
      csr_wdata <= CSR_DATA_W'(thr);
      @(negedge clock);
      csr_addr  <= CSR_MODE_KNOB;
      csr_wdata <= CSR_DATA_W'(mk);
      @(negedge clock);
      csr_we    <= 1'b0;
      mode_pick = KNOB_W'(mk);
   endtask

   // Next level for a knob in a well-formed scan.
   function automatic int next_level(input int k);
      int width;
      int lo;
      int hi;
      int v;
      int r;
      if (KNOB_W'(k) == mode_pick) begin
         width = ADC_FULL_SCALE / NUM_MODES;
         lo = page_pick * width;
         hi = (page_pick == NUM_MODES - 1) ? ADC_FULL_SCALE : lo + width - 1;
         return $urandom_range(lo, hi);
      end
      r = $urandom_range(0, 9);
      if (r < 3) begin
         return $urandom_range(0, ADC_FULL_SCALE);
      end else if (r < 7) begin
         v = int'(sent_level[k]) + int'($urandom_range(0, 80)) - 40;
         if (v < 0) begin
            v = 0;
         end else if (v > ADC_FULL_SCALE) begin
            v = ADC_FULL_SCALE;
         end
         return v;
      end
      return int'(sent_level[k]);
   endfunction

   // Mostly ordered scans with random content, some cut short, plus stray samples.
   task automatic random_phase(input int budget);
      int sent;
      int span;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 4) == 0) begin
               page_pick = $urandom_range(0, NUM_MODES - 1);
            end
            span = ($urandom_range(0, 5) == 0) ? $urandom_range(1, NUM_KNOBS) : NUM_KNOBS;
            for (int k = 0; k < span; k++) begin
               send(k, next_level(k), k == span - 1);
            end
            sent += span;
         end else begin
            send($urandom_range(0, NUM_KNOBS - 1), $urandom_range(0, ADC_FULL_SCALE),
                 $urandom_range(0, 2) == 0);
            sent++;
         end
      end
   endtask

   initial begin
      int phase_thr[PHASES];
      int phase_mk[PHASES];
      phase_thr = '{0, 4095, 100, 0, 0, 32};
      phase_mk  = '{7, 3, 5, 0, 0, 0};
      phase_thr[3] = $urandom_range(0, 200);
      phase_mk[3]  = $urandom_range(0, NUM_KNOBS - 1);
      phase_thr[4] = $urandom_range(0, ADC_FULL_SCALE);
      phase_mk[4]  = $urandom_range(0, NUM_KNOBS - 1);
      for (int i = 0; i < NUM_KNOBS; i++) begin
         sent_level[i] = '0;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part with reset settings: threshold 32, mode knob 0.
      // Movement equal to the threshold does not pick up, one more does.
      send(1, 32, 1'b0);
      send(2, 33, 1'b0);
      send(0, 0, 1'b1);
      // Every non-mode knob picked up: the largest batch of updates.
      send(1, 100, 1'b0);
      send(3, 4095, 1'b0);
      send(4, 4095, 1'b0);
      send(5, 'hAAA, 1'b0);
      send(6, 'h555, 1'b0);
      send(7, 4095, 1'b1);
      // Pickups persist across scans while the page holds.
      send(7, 4095, 1'b1);
      // Top of the first band, then the first step into the next page.
      send(0, 510, 1'b1);
      send(0, 511, 1'b1);
      // Near full scale lands past the last band and is clamped; no pickups left.
      send(0, 4088, 1'b1);
      send(0, 4095, 1'b1);
      send(7, 0, 1'b0);
      send(3, 4063, 1'b0);
      send(4, 4062, 1'b1);
      send(0, 4087, 1'b1);
      send(0, 0, 1'b1);

      // Random part across several register settings.
      for (int ph = 0; ph < PHASES; ph++) begin
         program_regs(phase_thr[ph], phase_mk[ph]);
         page_pick = $urandom_range(0, NUM_MODES - 1);
         calm = (ph == 2);
         random_phase(16);
      end
      calm = 1'b0;

      settle();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
